@@ src/encoder_turn_position_tracker_macros.svh @@
// ---------------------------------------------------------------------------
// Encoder turn position tracker assertion macros
// Shorthand for the concurrent assertions of the port checker.
// ---------------------------------------------------------------------------
`ifndef ENCODER_TURN_POSITION_TRACKER_MACROS_SVH
`define ENCODER_TURN_POSITION_TRACKER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ETPT_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ETPT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/etpt_pkg.sv @@
// ---------------------------------------------------------------------------
// Encoder turn position tracker package
// Shared widths, register indexes, input codes and divider status type.
// ---------------------------------------------------------------------------
package etpt_pkg;

   localparam int COUNTER_BITS_DEFAULT = 16;
   localparam int REQ_COUNT_W          = 16;
   localparam int TICKS_W              = 32;
   localparam int DIVISOR_W            = TICKS_W + 1;
   localparam int SEG_W                = 17;
   localparam int POSITION_W           = 32;
   localparam int CSR_INDEX_W          = 2;
   localparam int CSR_DATA_W           = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_TICKS_PER_TURN = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_USE_INDEX      = CSR_INDEX_W'(1);

   localparam logic [TICKS_W-1:0] TICKS_RESET = TICKS_W'(1);

   typedef enum logic {
      ACT_READ  = 1'b0,
      ACT_INDEX = 1'b1
   } etpt_action_type;

   typedef struct packed {
      logic busy;
      logic done;
   } etpt_div_status_type;

endpackage

@@ src/etpt_div.sv @@
// ---------------------------------------------------------------------------
// Encoder turn position tracker segment divider
// Restoring divider, one quotient bit per cycle, for the segment length.
// ---------------------------------------------------------------------------
module etpt_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [etpt_pkg::TICKS_W-1:0]   dividend,
   input  logic [etpt_pkg::DIVISOR_W-1:0] divisor,
   output etpt_pkg::etpt_div_status_type status,
   output logic [etpt_pkg::TICKS_W-1:0]   quotient
);
   import etpt_pkg::*;

   localparam int STEPS  = TICKS_W;
   localparam int STEP_W = $clog2(STEPS);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic [TICKS_W-1:0]   quo_ff, quo_in;
   logic [DIVISOR_W-1:0] rem_ff, rem_in;
   logic [DIVISOR_W-1:0] dsr_ff, dsr_in;
   logic [DIVISOR_W:0]   shifted;
   logic                 fits;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      shifted = {rem_ff, quo_ff[TICKS_W-1]};
      fits    = shifted >= {1'b0, dsr_ff};
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         // Bring down the next dividend bit and keep the trial difference if it fits.
         rem_in  = fits ? DIVISOR_W'(shifted - {1'b0, dsr_ff}) : DIVISOR_W'(shifted);
         quo_in  = {quo_ff[TICKS_W-2:0], fits};
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;

endmodule

@@ src/encoder_turn_position_tracker.sv @@
// ---------------------------------------------------------------------------
// Encoder turn position tracker
// Extends a wrapping encoder counter into a position within one turn.
// ---------------------------------------------------------------------------
// A read passes through the input register and then the result register.
// Throughput: one request per cycle while results are taken and the divider is idle. While
// a result waits for rsp_ready, one more request is taken into the input register; a read
// then waits there and req_ready stays low. A write of ticks_per_turn runs the segment
// divider, during which req_ready is low. Reset is synchronous and active high: use_index 0,
// segment length and count 1 (a turn of one tick), wrap count and previous sample 0.
module encoder_turn_position_tracker #(
   parameter int COUNTER_BITS = etpt_pkg::COUNTER_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_action,
   input  logic [etpt_pkg::REQ_COUNT_W-1:0] req_counter_value,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [etpt_pkg::POSITION_W-1:0]  rsp_position,
   input  logic                            csr_write,
   input  logic [etpt_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [etpt_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import etpt_pkg::*;

   // Only the low bits of the sample that the hardware counter really has are used.
   localparam int CW = (COUNTER_BITS < REQ_COUNT_W) ? COUNTER_BITS : REQ_COUNT_W;

   // Configuration and tracking state.
   logic               use_index_ff, use_index_in;
   logic               index_seen_ff, index_seen_in;
   logic [SEG_W-1:0]   seg_len_ff, seg_len_in;
   logic [SEG_W-1:0]   seg_cnt_ff, seg_cnt_in;
   logic [CW-1:0]      prev_ff, prev_in;
   logic [SEG_W-1:0]   wrap_ff, wrap_in;

   // Input register and result register.
   logic               in_valid_ff, in_valid_in;
   logic               in_action_ff;
   logic [CW-1:0]      in_count_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [POSITION_W-1:0] rsp_position_ff, rsp_position_in;

   // Divider interface and datapath signals.
   etpt_div_status_type div_status;
   logic [TICKS_W-1:0]   div_quotient;
   logic                 div_start;
   logic [TICKS_W-1:0]   ticks_eff;
   logic [DIVISOR_W-1:0] seg_cnt_full;
   logic                 use_index_new;
   logic                 advance;
   logic                 is_read;
   logic [CW:0]          diff;
   logic [CW:0]          mag;
   logic                 jump;
   logic [SEG_W:0]       wrap_inc;
   logic [SEG_W-1:0]     wrap_fwd;
   logic [SEG_W-1:0]     wrap_bwd;
   logic [SEG_W-1:0]     wrap_next;
   logic [2*SEG_W-1:0]   product;

   // The segment count comes straight from the written value; the segment
   // length, a true division, is produced by the iterative divider.
   assign ticks_eff    = (csr_wdata == '0) ? TICKS_W'(1) : csr_wdata;
   assign seg_cnt_full = ({1'b0, ticks_eff} >> COUNTER_BITS) + DIVISOR_W'(1);
   assign div_start    = csr_write && (csr_index == CSR_TICKS_PER_TURN);

   etpt_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (ticks_eff),
      .divisor  (seg_cnt_full),
      .status   (div_status),
      .quotient (div_quotient)
   );

   // An index mark leaves without a result, so it never waits on the output.
   // Nothing leaves the input register while the segment length is recomputed.
   assign is_read   = (in_action_ff == ACT_READ);
   assign advance   = in_valid_ff && !div_status.busy
                      && (!is_read || !rsp_valid_ff || rsp_ready);
   assign req_ready = !div_status.busy && (!in_valid_ff || advance);

   // Wrap detection: a jump of more than half a segment is a wrap; a backward
   // jump of the counter means it rolled over forward.
   assign diff     = {1'b0, in_count_ff} - {1'b0, prev_ff};
   assign mag      = diff[CW] ? (CW+1)'(-diff) : diff;
   assign jump     = DIVISOR_W'(mag) > DIVISOR_W'(seg_len_ff[SEG_W-1:1]);
   assign wrap_inc = {1'b0, wrap_ff} + (SEG_W+1)'(1);
   assign wrap_fwd = (wrap_inc >= {1'b0, seg_cnt_ff})
                     ? SEG_W'(wrap_inc - {1'b0, seg_cnt_ff}) : SEG_W'(wrap_inc);
   assign wrap_bwd = (wrap_ff == '0) ? SEG_W'(seg_cnt_ff - SEG_W'(1))
                                     : SEG_W'(wrap_ff - SEG_W'(1));

   always_comb begin
      priority if (!jump) begin
         wrap_next = wrap_ff;
      end else if (diff[CW]) begin
         wrap_next = wrap_fwd;
      end else begin
         wrap_next = wrap_bwd;
      end
   end

   assign product = wrap_next * seg_len_ff;

   always_comb begin
      use_index_in    = use_index_ff;
      index_seen_in   = index_seen_ff;
      seg_len_in      = seg_len_ff;
      seg_cnt_in      = seg_cnt_ff;
      prev_in         = prev_ff;
      wrap_in         = wrap_ff;
      rsp_position_in = rsp_position_ff;
      in_valid_in     = in_valid_ff;
      rsp_valid_in    = rsp_valid_ff;
      use_index_new   = (csr_index == CSR_USE_INDEX) ? csr_wdata[0] : use_index_ff;

      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (advance) begin
         if (!is_read) begin
            index_seen_in = 1'b1;
         end else begin
            rsp_valid_in = 1'b1;
            if (!index_seen_ff) begin
               // Before the index mark the position is not known yet.
               rsp_position_in = '0;
            end else begin
               wrap_in         = wrap_next;
               prev_in         = in_count_ff;
               rsp_position_in = POSITION_W'(in_count_ff) + product[POSITION_W-1:0];
            end
         end
      end

      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      // The user must write configuration only while the block is idle; the block does not enforce it.
      if (csr_write) begin
         unique case (csr_index)
            CSR_TICKS_PER_TURN: begin
               seg_cnt_in    = (seg_cnt_full[SEG_W-1:0] == '0) ? SEG_W'(1)
                                                               : seg_cnt_full[SEG_W-1:0];
               index_seen_in = !use_index_ff;
            end
            CSR_USE_INDEX: begin
               use_index_in  = use_index_new;
               index_seen_in = !use_index_new;
            end
            default: begin
            end
         endcase
      end

      if (div_status.done) begin
         seg_len_in = div_quotient[SEG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         use_index_ff  <= 1'b0;
         index_seen_ff <= 1'b1;
         seg_len_ff    <= SEG_W'(1);
         seg_cnt_ff    <= SEG_W'(1);
         prev_ff       <= '0;
         wrap_ff       <= '0;
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         use_index_ff  <= use_index_in;
         index_seen_ff <= index_seen_in;
         seg_len_ff    <= seg_len_in;
         seg_cnt_ff    <= seg_cnt_in;
         prev_ff       <= prev_in;
         wrap_ff       <= wrap_in;
         in_valid_ff   <= in_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      rsp_position_ff <= rsp_position_in;
      if (req_valid && req_ready) begin
         in_action_ff <= req_action;
         in_count_ff  <= req_counter_value[CW-1:0];
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_position = rsp_position_ff;

endmodule

@@ src/etpt_checker.sv @@
// ---------------------------------------------------------------------------
// Encoder turn position tracker port checker
// Watches the top level's ports for result and configuration behavior.
// ---------------------------------------------------------------------------
`include "encoder_turn_position_tracker_macros.svh"

module etpt_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [etpt_pkg::POSITION_W-1:0]  rsp_position,
   input logic                            csr_write,
   input logic [etpt_pkg::CSR_INDEX_W-1:0] csr_index
);
   import etpt_pkg::*;

   // A stalled result stays offered and unchanged.
   `ETPT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_position), "stalled result changed or dropped")

   // A turn length write stops request transfers while the segment length is recomputed.
   `ETPT_ASSERT_NEXT(a_div_blocks, clock, reset, csr_write && (csr_index == CSR_TICKS_PER_TURN), !req_ready, "request taken during segment division")

   // With nothing taken in and no result shown, no result can appear.
   `ETPT_ASSERT_NEXT(a_no_phantom, clock, reset, !req_ready && !rsp_valid, !rsp_valid, "result appeared without a pending request")

   // Reset leaves no result pending.
   `ETPT_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid, "result pending after reset")

endmodule

bind encoder_turn_position_tracker etpt_checker u_etpt_checker (.*);
